@@ rtl/priority_message_queue_top_assert.svh @@
// Assertion macros shared by the priority message queue modules.
// Expects signals named clk and rst in the scope of each use.
`ifndef PRIORITY_MESSAGE_QUEUE_TOP_ASSERT_SVH
`define PRIORITY_MESSAGE_QUEUE_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define PMQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define PMQ_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PMQ_ASSERT(lbl, prop, msg)
`define PMQ_ASSERT_RST(lbl, prop, msg)
`endif
`endif

@@ rtl/pmq_pkg.sv @@
// Shared types and constants of the priority message queue.
// Used by the controller, the datapath and the top level; depends on nothing.
package pmq_pkg;

  localparam int FUNC_W   = 2;
  localparam int PRIO_W   = 8;
  localparam int CAP_W    = 5;
  localparam int WORD_W   = 32;

  localparam logic [FUNC_W-1:0] FUNC_PUT   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_GET   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_FLUSH = 2'd2;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;   // latch the incoming word and priority
    logic exec;   // apply the operation and register the result
    logic put;
    logic get;
    logic flush;
    logic err;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic full;
    logic empty;
  } stat_t;

endpackage

@@ rtl/pmq_ctrl.sv @@
// Controller of the priority message queue: accepts a command word, decodes it
// against the queue status and steps the datapath. Depends on pmq_pkg.
`include "priority_message_queue_top_assert.svh"

module pmq_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [pmq_pkg::FUNC_W-1:0]  func,
  input  pmq_pkg::stat_t              stat,
  output logic                        busy,
  output logic                        cfg_ready,
  output logic                        done,
  output pmq_pkg::cmd_t               cmd
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;
  logic   put_q, get_q, flush_q, err_q;
  logic   put_d, get_d, flush_d, err_d;

  assign accept    = (state == ST_IDLE) && start;
  assign busy      = (state == ST_EXEC);
  assign cfg_ready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // A put to a full queue or a get from an empty one is decided at accept;
  // nothing changes the queue between accept and execution.
  always_comb begin
    put_d   = 1'b0;
    get_d   = 1'b0;
    flush_d = 1'b0;
    err_d   = 1'b0;
    unique case (func)
      pmq_pkg::FUNC_PUT: begin
        put_d = !stat.full;
        err_d = stat.full;
      end
      pmq_pkg::FUNC_GET: begin
        get_d = !stat.empty;
        err_d = stat.empty;
      end
      pmq_pkg::FUNC_FLUSH: begin
        flush_d = 1'b1;
      end
      default: begin
        err_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      done    <= 1'b0;
      put_q   <= 1'b0;
      get_q   <= 1'b0;
      flush_q <= 1'b0;
      err_q   <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == ST_EXEC);
      if (accept) begin
        put_q   <= put_d;
        get_q   <= get_d;
        flush_q <= flush_d;
        err_q   <= err_d;
      end
    end
  end

  always_comb begin
    cmd.load  = accept;
    cmd.exec  = (state == ST_EXEC);
    cmd.put   = (state == ST_EXEC) && put_q;
    cmd.get   = (state == ST_EXEC) && get_q;
    cmd.flush = (state == ST_EXEC) && flush_q;
    cmd.err   = (state == ST_EXEC) && err_q;
  end

  `PMQ_ASSERT(a_done_after_exec, done |-> $past(state == ST_EXEC), "done without execution")
  `PMQ_ASSERT(a_exec_single, (state == ST_EXEC) |=> (state == ST_IDLE), "execution overran")
  `PMQ_ASSERT(a_one_op, $onehot0({cmd.put, cmd.get, cmd.flush, cmd.err}), "conflicting ops")
  `PMQ_ASSERT_RST(a_reset_idle, rst |=> ((state == ST_IDLE) && !done), "reset not idle")

endmodule

@@ rtl/pmq_dp.sv @@
// Datapath of the priority message queue: a row of sorted cells with
// compare-and-shift insert and head removal, fill count, capacity and result
// registers. Depends on pmq_pkg.
`include "priority_message_queue_top_assert.svh"

module pmq_dp #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  pmq_pkg::cmd_t               cmd,
  output pmq_pkg::stat_t              stat,
  input  logic [pmq_pkg::WORD_W-1:0]  data_in,
  input  logic [pmq_pkg::PRIO_W-1:0]  prio_in,
  input  logic                        cfg_wr,
  input  logic [pmq_pkg::CAP_W-1:0]   cfg_data,
  output logic                        status,
  output logic [pmq_pkg::WORD_W-1:0]  data_out,
  output logic [pmq_pkg::PRIO_W-1:0]  prio_out,
  output logic [pmq_pkg::CAP_W-1:0]   count,
  output logic [pmq_pkg::CAP_W-1:0]   space
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = (CW > pmq_pkg::CAP_W) ? CW : pmq_pkg::CAP_W;

  logic [DATA_WIDTH-1:0]      cell_data [DEPTH];
  logic [pmq_pkg::PRIO_W-1:0] cell_prio [DEPTH];
  logic [CW-1:0]              fill_count;
  logic [CW-1:0]              fill_next;
  logic [pmq_pkg::CAP_W-1:0]  capacity;
  logic [DATA_WIDTH-1:0]      data_q;
  logic [pmq_pkg::PRIO_W-1:0] prio_q;
  logic [DEPTH-1:0]           ins_le;
  logic [SW-1:0]              usable;
  logic [SW-1:0]              fill_w;
  logic [SW-1:0]              space_w;
  logic [63:0]                in_wide;
  logic [63:0]                head_wide;

  assign in_wide   = 64'(data_in);
  assign head_wide = 64'(cell_data[0]);

  // A capacity above the built depth acts as the depth.
  assign usable = (SW'(capacity) > SW'(DEPTH)) ? SW'(DEPTH) : SW'(capacity);

  assign stat.full  = (SW'(fill_count) >= usable);
  assign stat.empty = (fill_count == '0);

  always_comb begin
    fill_next = fill_count;
    if (cmd.put) begin
      fill_next = fill_count + CW'(1);
    end else if (cmd.get) begin
      fill_next = fill_count - CW'(1);
    end else if (cmd.flush) begin
      fill_next = '0;
    end
  end

  assign fill_w  = SW'(fill_next);
  assign space_w = (usable > fill_w) ? (usable - fill_w) : '0;

  // Cells are kept in descending priority order, so ins_le is set for every
  // cell at or after the insert point: the first stored entry of strictly
  // lower priority, or the tail. A priority of zero always goes to the tail.
  genvar i;
  generate
    for (i = 0; i < DEPTH; i++) begin : g_cell
      assign ins_le[i] = !(CW'(i) < fill_count) ||
                         ((prio_q != '0) && (cell_prio[i] < prio_q));

      always_ff @(posedge clk) begin
        if (cmd.put && ins_le[i]) begin
          if (i == 0) begin
            cell_data[i] <= data_q;
            cell_prio[i] <= prio_q;
          end else if (!ins_le[(i == 0) ? 0 : i - 1]) begin
            cell_data[i] <= data_q;
            cell_prio[i] <= prio_q;
          end else begin
            cell_data[i] <= cell_data[(i == 0) ? 0 : i - 1];
            cell_prio[i] <= cell_prio[(i == 0) ? 0 : i - 1];
          end
        end else if (cmd.get && (i < DEPTH - 1)) begin
          cell_data[i] <= cell_data[(i < DEPTH - 1) ? i + 1 : i];
          cell_prio[i] <= cell_prio[(i < DEPTH - 1) ? i + 1 : i];
        end
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
      capacity   <= pmq_pkg::CAP_RESET;
    end else begin
      fill_count <= fill_next;
      if (cfg_wr) capacity <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      data_q <= in_wide[DATA_WIDTH-1:0];
      prio_q <= prio_in;
    end
    if (cmd.exec) begin
      status   <= cmd.err;
      data_out <= cmd.get ? head_wide[pmq_pkg::WORD_W-1:0] : '0;
      prio_out <= cmd.get ? cell_prio[0] : '0;
      count    <= fill_w[pmq_pkg::CAP_W-1:0];
      space    <= space_w[pmq_pkg::CAP_W-1:0];
    end
  end

  `PMQ_ASSERT(a_fill_bound, fill_count <= CW'(DEPTH), "fill count above depth")
  `PMQ_ASSERT(a_put_grows, cmd.put |=> (fill_count == $past(fill_count) + CW'(1)), "put lost")
  `PMQ_ASSERT(a_head_order, (fill_count >= CW'(2)) |-> (cell_prio[0] >= cell_prio[1]), "unsorted head")

endmodule

@@ rtl/priority_message_queue_top.sv @@
// Top level of the priority message queue: controller plus cell-row datapath.
// Depends on pmq_pkg, pmq_ctrl and pmq_dp.
//
//   channel   handshake               payload
//   command   start / busy            func, data_in, prio_in
//   result    done (strobe)           status, data_out, prio_out, count, space
//   config    cfg_valid / cfg_ready   cfg_data (capacity)
//
// An operation is accepted and decoded in the idle state; in the execute state
// the cell row shifts, and the result registers and done load together.
// A new command is taken in the cycle that the previous result is shown.
// Synchronous active-high reset empties the queue and sets capacity to 16.
// The receiver cannot stall; every result is shown for exactly one cycle.
module priority_message_queue_top #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [pmq_pkg::FUNC_W-1:0]  func,
  input  logic [pmq_pkg::WORD_W-1:0]  data_in,
  input  logic [pmq_pkg::PRIO_W-1:0]  prio_in,
  output logic                        done,
  output logic                        status,
  output logic [pmq_pkg::WORD_W-1:0]  data_out,
  output logic [pmq_pkg::PRIO_W-1:0]  prio_out,
  output logic [pmq_pkg::CAP_W-1:0]   count,
  output logic [pmq_pkg::CAP_W-1:0]   space,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [pmq_pkg::CAP_W-1:0]   cfg_data
);

  pmq_pkg::cmd_t  cmd;
  pmq_pkg::stat_t stat;

  pmq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .func      (func),
    .stat      (stat),
    .busy      (busy),
    .cfg_ready (cfg_ready),
    .done      (done),
    .cmd       (cmd)
  );

  pmq_dp #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .data_in  (data_in),
    .prio_in  (prio_in),
    .cfg_wr   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .status   (status),
    .data_out (data_out),
    .prio_out (prio_out),
    .count    (count),
    .space    (space)
  );

endmodule

@@ sim/priority_message_queue_top_test.sv @@
`timescale 1ns / 100ps
// Self-checking testbench of the priority message queue top level.
// Drives commands and capacity writes, predicts each reply in a local model
// of the sorted queue, and compares every field. Depends on pmq_pkg and the RTL.
module priority_message_queue_top_test;

  localparam int SLOTS = 16;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam logic [pmq_pkg::FUNC_W-1:0] FUNC_NONE = 2'd3;

  typedef struct packed {
    logic [pmq_pkg::FUNC_W-1:0] func;
    logic [pmq_pkg::WORD_W-1:0] data;
    logic [pmq_pkg::PRIO_W-1:0] prio;
    logic [4:0]                 gap;
    logic                       hold;
  } op_t;

  typedef struct packed {
    logic                       status;
    logic [pmq_pkg::WORD_W-1:0] data_out;
    logic [pmq_pkg::PRIO_W-1:0] prio_out;
    logic [pmq_pkg::CAP_W-1:0]  count;
    logic [pmq_pkg::CAP_W-1:0]  space;
  } reply_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [pmq_pkg::FUNC_W-1:0] func = '0;
  logic [pmq_pkg::WORD_W-1:0] data_in = '0;
  logic [pmq_pkg::PRIO_W-1:0] prio_in = '0;
  logic done;
  logic status;
  logic [pmq_pkg::WORD_W-1:0] data_out;
  logic [pmq_pkg::PRIO_W-1:0] prio_out;
  logic [pmq_pkg::CAP_W-1:0] count;
  logic [pmq_pkg::CAP_W-1:0] space;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [pmq_pkg::CAP_W-1:0] cfg_data = '0;

  priority_message_queue_top DUT (
    .clk(clk), .rst(rst),
    .start(start), .busy(busy),
    .func(func), .data_in(data_in), .prio_in(prio_in),
    .done(done), .status(status), .data_out(data_out), .prio_out(prio_out),
    .count(count), .space(space),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  // Local copy of the queue contents, head at slot 0.
  logic [pmq_pkg::WORD_W-1:0] held_word [SLOTS];
  logic [pmq_pkg::PRIO_W-1:0] held_prio [SLOTS];
  int held_count = 0;
  logic [pmq_pkg::CAP_W-1:0] cap_model = pmq_pkg::CAP_RESET;

  op_t ops_to_send[$];
  reply_t replies_due[$];
  int ops_queued = 0;
  int replies_seen = 0;
  int errors = 0;
  int idle_cycles = 0;
  bit op_taken = 0;

  task automatic model_queue_op(input logic [pmq_pkg::FUNC_W-1:0] f,
                                input logic [pmq_pkg::WORD_W-1:0] w,
                                input logic [pmq_pkg::PRIO_W-1:0] p,
                                output reply_t r);
    int usable;
    int pos;
    int room;
    bit found;
    r = '0;
    usable = (int'(cap_model) > SLOTS) ? SLOTS : int'(cap_model);
    case (f)
      pmq_pkg::FUNC_PUT: begin
        if (held_count >= usable) begin
          r.status = 1'b1;
        end else begin
          pos = held_count;
          found = 0;
          // Nonzero priority goes ahead of the first strictly lower entry.
          if (p != 0) begin
            for (int i = 0; i < held_count; i++) begin
              if (!found && held_prio[i] < p) begin
                pos = i;
                found = 1;
              end
            end
          end
          for (int i = held_count; i > pos; i--) begin
            held_word[i] = held_word[i-1];
            held_prio[i] = held_prio[i-1];
          end
          held_word[pos] = w;
          held_prio[pos] = p;
          held_count++;
        end
      end
      pmq_pkg::FUNC_GET: begin
        if (held_count == 0) begin
          r.status = 1'b1;
        end else begin
          r.data_out = held_word[0];
          r.prio_out = held_prio[0];
          for (int i = 1; i < held_count; i++) begin
            held_word[i-1] = held_word[i];
            held_prio[i-1] = held_prio[i];
          end
          held_count--;
        end
      end
      pmq_pkg::FUNC_FLUSH: begin
        held_count = 0;
      end
      default: begin
      end
    endcase
    room = (usable > held_count) ? (usable - held_count) : 0;
    r.count = held_count[pmq_pkg::CAP_W-1:0];
    r.space = room[pmq_pkg::CAP_W-1:0];
  endtask

  task automatic report(input string field, input logic [pmq_pkg::WORD_W-1:0] want,
                        input logic [pmq_pkg::WORD_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
      errors++;
    end
  endtask

  // Reply checking, command acceptance and the model's capacity copy.
  always @(posedge clk) begin : monitor
    reply_t want;
    reply_t calc;
    bit moved;
    moved = 0;
    if (!rst) begin
      if (done) begin
        moved = 1;
        if (replies_due.size() == 0) begin
          $display("%0t: unexpected reply, expected none, actual %b %h %h %0d %0d",
                   $time, status, data_out, prio_out, count, space);
          errors++;
        end else begin
          want = replies_due.pop_front();
          report("status", pmq_pkg::WORD_W'(want.status), pmq_pkg::WORD_W'(status));
          report("data_out", want.data_out, data_out);
          report("prio_out", pmq_pkg::WORD_W'(want.prio_out), pmq_pkg::WORD_W'(prio_out));
          report("count", pmq_pkg::WORD_W'(want.count), pmq_pkg::WORD_W'(count));
          report("space", pmq_pkg::WORD_W'(want.space), pmq_pkg::WORD_W'(space));
          replies_seen++;
        end
      end
      if (start && !busy) begin
        model_queue_op(func, data_in, prio_in, calc);
        replies_due.push_back(calc);
        op_taken = 1;
        moved = 1;
      end
      if (cfg_valid && cfg_ready) begin
        cap_model = cfg_data;
        moved = 1;
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
    end
  end

  always @(posedge clk) begin
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Command driver: one word at a time from ops_to_send, changing at the falling edge.
  op_t cur_op;
  bit have_op = 0;
  int gap_left = 0;

  always @(negedge clk) begin : driver
    logic next_start;
    next_start = 1'b0;
    if (!rst) begin
      if (op_taken) begin
        op_taken = 0;
        have_op = 0;
      end
      if (!have_op && ops_to_send.size() > 0) begin
        cur_op = ops_to_send.pop_front();
        have_op = 1;
        gap_left = int'(cur_op.gap);
      end
      if (have_op) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (!(cur_op.hold && replies_due.size() > 0)) begin
          next_start = 1'b1;
          func <= cur_op.func;
          data_in <= cur_op.data;
          prio_in <= cur_op.prio;
        end
      end
    end
    start <= next_start;
  end

  task automatic add_op(input logic [pmq_pkg::FUNC_W-1:0] f,
                        input logic [pmq_pkg::WORD_W-1:0] w,
                        input logic [pmq_pkg::PRIO_W-1:0] p, input int gap, input bit hold);
    op_t o;
    o.func = f;
    o.data = w;
    o.prio = p;
    o.gap = gap[4:0];
    o.hold = hold;
    ops_to_send.push_back(o);
    ops_queued++;
  endtask

  task automatic wait_drained;
    while (replies_seen != ops_queued) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [pmq_pkg::CAP_W-1:0] v);
    @(negedge clk);
    cfg_data <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_phase(input int n, input int put_pct, input int idle_mode);
    logic [pmq_pkg::FUNC_W-1:0] f;
    logic [pmq_pkg::WORD_W-1:0] w;
    logic [pmq_pkg::PRIO_W-1:0] p;
    int r;
    int gap;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (r < put_pct) f = pmq_pkg::FUNC_PUT;
      else if (r < 96) f = pmq_pkg::FUNC_GET;
      else if (r < 98) f = pmq_pkg::FUNC_FLUSH;
      else f = FUNC_NONE;
      r = $urandom_range(0, 9);
      if (r == 0) w = '0;
      else if (r == 1) w = '1;
      else w = $urandom;
      // Small priorities give plenty of ties to test first-in, first-out order.
      r = $urandom_range(0, 9);
      if (r < 2) p = '0;
      else if (r < 6) p = pmq_pkg::PRIO_W'($urandom_range(1, 4));
      else if (r == 6) p = '1;
      else p = pmq_pkg::PRIO_W'($urandom_range(0, 255));
      case (idle_mode)
        0: gap = 0;
        1: gap = $urandom_range(0, 18);
        default: gap = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 18) : 0;
      endcase
      add_op(f, w, p, gap, $urandom_range(0, 49) == 0);
    end
  endtask

  int caps [12] = '{16, 8, 3, 0, 1, 31, 20, 16, 12, 2, 17, 5};
  int puts [12] = '{75, 40, 60, 55, 70, 50, 80, 45, 60, 65, 50, 35};

  initial begin
    repeat (11) @(negedge clk);
    rst <= 1'b0;

    // Reset capacity: empty get, unused code, ties, both tail cases, flush.
    add_op(pmq_pkg::FUNC_GET, 32'h1234_5678, 8'h10, 0, 0);
    add_op(FUNC_NONE, '1, '1, 0, 0);
    add_op(pmq_pkg::FUNC_FLUSH, '0, '0, 3, 0);
    add_op(pmq_pkg::FUNC_PUT, '1, 8'd0, 0, 0);
    add_op(pmq_pkg::FUNC_PUT, '0, 8'd255, 0, 0);
    add_op(pmq_pkg::FUNC_PUT, 32'hA5A5_0001, 8'd7, 5, 0);
    add_op(pmq_pkg::FUNC_PUT, 32'h5A5A_0002, 8'd7, 0, 0);
    add_op(pmq_pkg::FUNC_PUT, 32'hC3C3_0003, 8'd0, 0, 1);
    add_op(pmq_pkg::FUNC_PUT, 32'h3C3C_0004, 8'd255, 0, 0);
    add_op(pmq_pkg::FUNC_PUT, 32'h0F0F_0005, 8'd1, 2, 0);
    add_op(pmq_pkg::FUNC_GET, '0, '1, 0, 0);
    add_op(pmq_pkg::FUNC_GET, '0, '0, 0, 0);
    add_op(pmq_pkg::FUNC_GET, '1, '0, 7, 0);
    add_op(pmq_pkg::FUNC_FLUSH, '1, '1, 0, 0);
    add_op(pmq_pkg::FUNC_GET, '0, '0, 0, 0);
    wait_drained();

    // Capacity two: fill, a put when full, then drain past empty.
    write_capacity(5'd2);
    add_op(pmq_pkg::FUNC_PUT, 32'hDEAD_BEEF, 8'd3, 0, 0);
    add_op(pmq_pkg::FUNC_PUT, 32'hFEED_F00D, 8'd9, 0, 0);
    add_op(pmq_pkg::FUNC_PUT, 32'h0BAD_CAFE, 8'd200, 0, 0);
    add_op(FUNC_NONE, '0, '0, 0, 0);
    add_op(pmq_pkg::FUNC_GET, '0, '0, 0, 0);
    add_op(pmq_pkg::FUNC_GET, '0, '0, 0, 0);
    add_op(pmq_pkg::FUNC_GET, '0, '0, 0, 0);
    wait_drained();

    // Random phases; stored entries carry over, so lower capacities fall below the count.
    for (int ph = 0; ph < 12; ph++) begin
      write_capacity(caps[ph][pmq_pkg::CAP_W-1:0]);
      random_phase(150, puts[ph], ph % 3);
      wait_drained();
    end

    if (replies_due.size() != 0) begin
      $display("%0t: %0d replies never arrived", $time, replies_due.size());
      errors++;
    end
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
